>>> rtl/core/bbot_pkg.sv
// ----------------------------------------------------------------------------
// bbot_pkg
// Shared types and constants of the Buddhabrot orbit tracer.
// ----------------------------------------------------------------------------
package bbot_pkg;

  localparam int FRAC_BITS_DEF  = 28;
  localparam int TRACE_MAX_DEF  = 63;
  localparam int COORD_BITS_DEF = 12;

  localparam int CFG_DW      = 64;
  localparam int CFG_AW      = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int PIX_W       = 20;
  localparam int BAND_W      = 6;

  // register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_MAX_ITER   = 3'd0;
  localparam logic [2:0] REG_MIN_ITER   = 3'd1;
  localparam logic [2:0] REG_BANDS      = 3'd2;
  localparam logic [2:0] REG_VIEW_LEFT  = 3'd3;
  localparam logic [2:0] REG_VIEW_TOP   = 3'd4;
  localparam logic [2:0] REG_X_PPU      = 3'd5;
  localparam logic [2:0] REG_Y_PPU      = 3'd6;
  localparam logic [2:0] REG_IMAGE_SIZE = 3'd7;

  localparam logic [15:0] MAX_ITER_RST   = 16'd50000;
  localparam logic [15:0] MIN_ITER_RST   = 16'd10000;
  localparam logic [35:0] BANDS_RST      = 36'd21659648642;
  localparam logic [31:0] VIEW_LEFT_RST  = 32'hE000_0000;
  localparam logic [31:0] VIEW_TOP_RST   = 32'hF000_0000;
  localparam logic [31:0] X_PPU_RST      = 32'd6553600;
  localparam logic [31:0] Y_PPU_RST      = 32'd6553600;
  localparam logic [23:0] IMAGE_SIZE_RST = 24'd819500;

  typedef struct packed {
    logic signed [31:0] point_real;
    logic signed [31:0] point_imag;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [PIX_W-1:0] pixel_y_mirror;
    logic             draw;
    logic             red_hit;
    logic             green_hit;
    logic             blue_hit;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    logic               reject;
  } job_t;

  typedef struct packed {
    logic [15:0]        max_iter;
    logic [15:0]        min_iter;
    logic [35:0]        bands;
    logic signed [31:0] view_left;
    logic signed [31:0] view_top;
    logic [31:0]        x_ppu;
    logic [31:0]        y_ppu;
    logic [23:0]        image_size;
  } cfg_t;

endpackage

>>> rtl/core/bbot_mul.sv
// ----------------------------------------------------------------------------
// bbot_mul
// Unsigned W x W multiplier, four half-width partial products accumulated in turn.
// ----------------------------------------------------------------------------
module bbot_mul import bbot_pkg::*; #(
  parameter int W = FRAC_BITS_DEF + 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic           done,
  output logic [2*W-1:0] prod
);

  localparam int H = (W + 1) / 2;

  logic [W-1:0]   a_r, b_r;
  logic [2*W-1:0] acc_r;
  logic [1:0]     ph_r;
  logic           run_r, done_r;
  logic [H-1:0]   opa, opb;
  logic [2*H-1:0] pp;
  logic [2*W-1:0] term;

  always_comb begin
    opa  = ph_r[1] ? H'(a_r >> H) : a_r[H-1:0];
    opb  = ph_r[0] ? H'(b_r >> H) : b_r[H-1:0];
    pp   = opa * opb;
    case (ph_r)
      2'd0:    term = (2*W)'(pp);
      2'd3:    term = (2*W)'(pp) << (2 * H);
      default: term = (2*W)'(pp) << H;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= run_r && (ph_r == 2'd3);
      if (start) begin
        run_r <= 1'b1;
        ph_r  <= 2'd0;
      end else if (run_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_r + term;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> rtl/core/bbot_fifo.sv
// ----------------------------------------------------------------------------
// bbot_fifo
// Short job queue between the classifier and the orbit engine.
// ----------------------------------------------------------------------------
module bbot_fifo import bbot_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          wr_en, rd_en;

  assign wr_ready = (cnt_r != CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      if (rd_en) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      if (wr_en && !rd_en) cnt_r <= cnt_r + CW'(1);
      else if (rd_en && !wr_en) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

>>> rtl/core/bbot_front.sv
// ----------------------------------------------------------------------------
// bbot_front
// Takes a sample point and runs the cardioid and period-2 bulb test.
// ----------------------------------------------------------------------------
module bbot_front import bbot_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t in_data,
  output logic     full,
  output logic     job_valid,
  input  logic     job_ready,
  output job_t     job
);

  localparam int W  = FRAC_BITS + 12;
  localparam int ZW = FRAC_BITS + 11;

  localparam logic [W-1:0] K108 = W'(((64'd108 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [W-1:0] K06  = W'(((64'd6 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [W-1:0] K417 = W'(((64'd417 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic signed [W:0] K42 = (W+1)'(((64'd42 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [W:0] K15 = (W+1)'(((64'd15 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic signed [W:0] ONE = (W+1)'(64'd1 << FRAC_BITS);
  localparam logic [ZW-1:0] ZLIM = '1;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  localparam logic [1:0] OP_T2   = 2'd0;
  localparam logic [1:0] OP_CI2  = 2'd1;
  localparam logic [1:0] OP_C2R  = 2'd2;
  localparam logic [1:0] OP_C2R2 = 2'd3;

  logic [1:0]         st_r, op_r;
  logic               iss_r, rej_r;
  logic signed [31:0] cr_r, ci_r;
  logic [ZW-1:0]      sq_t_r, sq_i_r;
  logic signed [W:0]  c2r_r;

  logic signed [W:0]  t_s, ci_s, cr_s, sat_s;
  logic [W-1:0]       t_m, ci_m, cr_m, c2r_m, ma, mb;
  logic               mul_start, mul_done;
  logic [2*W-1:0]     mul_prod;
  logic [2*W-1:0]     q;
  logic [ZW-1:0]      sat;

  always_comb begin
    cr_s  = (W+1)'(cr_r);
    ci_s  = (W+1)'(ci_r);
    t_s   = cr_s + ONE;
    t_m   = t_s[W] ? W'(-t_s) : W'(t_s);
    ci_m  = ci_s[W] ? W'(-ci_s) : W'(ci_s);
    cr_m  = cr_s[W] ? W'(-cr_s) : W'(cr_s);
    c2r_m = c2r_r[W] ? W'(-c2r_r) : W'(c2r_r);
    case (op_r)
      OP_T2:   begin ma = t_m;   mb = t_m;   end
      OP_CI2:  begin ma = ci_m;  mb = ci_m;  end
      OP_C2R:  begin ma = K108;  mb = cr_m;  end
      default: begin ma = c2r_m; mb = c2r_m; end
    endcase
    q     = mul_prod >> FRAC_BITS;
    sat   = (q > (2*W)'(ZLIM)) ? ZLIM : ZW'(q);
    sat_s = $signed({1'b0, sat});
  end

  assign mul_start = (st_r == F_MUL) && !iss_r;

  bbot_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      op_r  <= OP_T2;
      iss_r <= 1'b0;
    end else begin
      case (st_r)
        F_IDLE: begin
          if (push) begin
            st_r  <= F_MUL;
            op_r  <= OP_T2;
            iss_r <= 1'b0;
          end
        end
        F_MUL: begin
          if (mul_start) iss_r <= 1'b1;
          if (mul_done) begin
            iss_r <= 1'b0;
            op_r  <= op_r + 2'd1;
            if (op_r == OP_C2R2) st_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) st_r <= F_IDLE;
        end
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && push) begin
      cr_r <= in_data.point_real;
      ci_r <= in_data.point_imag;
    end
    if (mul_done) begin
      case (op_r)
        OP_T2:  sq_t_r <= sat;
        OP_CI2: sq_i_r <= sat;
        OP_C2R: c2r_r  <= (cr_r < 0 ? -sat_s : sat_s) + K15;
        default: begin
          rej_r <= (({1'b0, sq_t_r} + {1'b0, sq_i_r}) < K06) ||
                   ((c2r_r < K42) && (({1'b0, sat} + {1'b0, sq_i_r}) < K417));
        end
      endcase
    end
  end

  assign full      = (st_r != F_IDLE);
  assign job_valid = (st_r == F_PUSH);
  assign job       = '{cr: cr_r, ci: ci_r, reject: rej_r};

endmodule

>>> rtl/core/bbot_engine.sv
// ----------------------------------------------------------------------------
// bbot_engine
// Escape iteration and orbit trace of accepted points, one result at a time.
// ----------------------------------------------------------------------------
module bbot_engine import bbot_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TRACE_MAX  = TRACE_MAX_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  localparam int W    = FRAC_BITS + 12;
  localparam int ZW   = FRAC_BITS + 11;
  localparam int PW   = FRAC_BITS + 16;
  localparam int PIXB = (COORD_BITS + 8 > PIX_W) ? PIX_W : COORD_BITS + 8;

  localparam logic [W-1:0]  FOUR   = W'(64'd4 << FRAC_BITS);
  localparam logic [ZW-1:0] ZLIM   = '1;
  localparam logic signed [W+1:0] ZLIM_S = $signed({3'b000, ZLIM});
  localparam logic [PW-1:0] PIXMAX = (PW'(1) << PIXB) - PW'(1);

  localparam logic [1:0] E_IDLE  = 2'd0;
  localparam logic [1:0] E_MUL   = 2'd1;
  localparam logic [1:0] E_CHECK = 2'd2;
  localparam logic [1:0] E_EMIT  = 2'd3;

  localparam logic [2:0] OP_SQR   = 3'd0;
  localparam logic [2:0] OP_SQI   = 3'd1;
  localparam logic [2:0] OP_CROSS = 3'd2;
  localparam logic [2:0] OP_PIXX  = 3'd3;
  localparam logic [2:0] OP_PIXY  = 3'd4;
  localparam logic [2:0] OP_PIXM  = 3'd5;

  logic [1:0]          st_r;
  logic [2:0]          op_r;
  logic                iss_r, trace_r, fresh_r, rej_r, last_r;
  logic signed [31:0]  cr_r, ci_r;
  logic signed [W-1:0] zr_r, zi_r;
  logic [ZW-1:0]       a_r, b_r;
  logic [16:0]         n_r;
  logic [BAND_W-1:0]   i_r;
  logic [PIX_W-1:0]    px_r, py_r, pm_r;
  logic                okx_r, oky_r, okm_r;

  logic signed [W:0]   dx, dy, dm, dsel;
  logic [W-1:0]        zr_m, zi_m, d_m, ma, mb;
  logic [31:0]         ppu;
  logic [11:0]         size;
  logic                mul_start, mul_done;
  logic [2*W-1:0]      mul_prod, q;
  logic [ZW-1:0]       sat;
  logic signed [W+1:0] sat_s, p_s, re_sum, im_sum;
  logic signed [W-1:0] re_cl, im_cl;
  logic [PW-1:0]       pmag, plim;
  logic                pneg, pok;
  logic [PIX_W-1:0]    pval;
  logic [W-1:0]        norm_now, norm_new;
  logic                n_ok, cont, in_range, done_now;
  logic [BAND_W-1:0]   hi0, hi1, hi2, top01, top;

  function automatic logic signed [W-1:0] clampz(input logic signed [W+1:0] x);
    if (x > ZLIM_S) return W'(ZLIM_S);
    if (x < -ZLIM_S) return W'(-ZLIM_S);
    return W'(x);
  endfunction

  function automatic logic in_band(input logic [BAND_W-1:0] i, input logic [11:0] lim);
    return (i >= lim[5:0]) && (i <= lim[11:6]);
  endfunction

  always_comb begin
    zr_m = zr_r[W-1] ? W'(-zr_r) : W'(zr_r);
    zi_m = zi_r[W-1] ? W'(-zi_r) : W'(zi_r);
    dx   = (W+1)'(zr_r) - (W+1)'(cfg.view_left);
    dy   = (W+1)'(zi_r) - (W+1)'(cfg.view_top);
    dm   = -(W+1)'(zi_r) - (W+1)'(cfg.view_top);
    case (op_r)
      OP_PIXX: begin dsel = dx; ppu = cfg.x_ppu; size = cfg.image_size[11:0];  end
      OP_PIXY: begin dsel = dy; ppu = cfg.y_ppu; size = cfg.image_size[23:12]; end
      default: begin dsel = dm; ppu = cfg.y_ppu; size = cfg.image_size[23:12]; end
    endcase
    d_m = dsel[W] ? W'(-dsel) : W'(dsel);
    case (op_r)
      OP_SQR:   begin ma = zr_m; mb = zr_m; end
      OP_SQI:   begin ma = zi_m; mb = zi_m; end
      OP_CROSS: begin ma = zr_m; mb = zi_m; end
      default:  begin ma = d_m;  mb = W'(ppu); end
    endcase

    // z products: truncate and saturate
    q     = mul_prod >> FRAC_BITS;
    sat   = (q > (2*W)'(ZLIM)) ? ZLIM : ZW'(q);
    sat_s = $signed({3'b000, sat});
    p_s   = (zr_r[W-1] != zi_r[W-1]) ? -sat_s : sat_s;
    re_sum = $signed({3'b000, a_r}) - $signed({3'b000, b_r}) + (W+2)'(cr_r);
    im_sum = (p_s <<< 1) + (W+2)'(ci_r);
    re_cl  = clampz(re_sum);
    im_cl  = clampz(im_sum);

    // pixel position: negative offsets clamp to 0 and, unless the scale is zero, are out of view
    pmag = PW'(mul_prod >> (FRAC_BITS + 8));
    plim = PW'({size - 12'd1, 8'h00});
    pneg = dsel[W] && (ppu != '0);
    pok  = !pneg && (size >= 12'd2) && (pmag < plim);
    pval = pneg ? '0 : ((pmag > PIXMAX) ? PIX_W'(PIXMAX) : PIX_W'(pmag));

    norm_now = {1'b0, a_r} + {1'b0, b_r};
    norm_new = {1'b0, a_r} + {1'b0, sat};
    n_ok     = (n_r <= {1'b0, cfg.max_iter});
    cont     = n_ok && (norm_now < FOUR);
    in_range = n_ok && (n_r >= {1'b0, cfg.min_iter});

    hi0   = cfg.bands[11:6];
    hi1   = cfg.bands[23:18];
    hi2   = cfg.bands[35:30];
    top01 = (hi1 > hi0) ? hi1 : hi0;
    top   = (hi2 > top01) ? hi2 : top01;
    if (top > BAND_W'(TRACE_MAX)) top = BAND_W'(TRACE_MAX);
    done_now = (norm_new >= FOUR) || (i_r == top);
  end

  assign mul_start = (st_r == E_MUL) && !iss_r;

  bbot_mul #(.W(W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= E_IDLE;
      op_r    <= OP_SQR;
      iss_r   <= 1'b0;
      trace_r <= 1'b0;
      fresh_r <= 1'b0;
      rej_r   <= 1'b0;
    end else begin
      case (st_r)
        E_IDLE: begin
          if (job_valid) begin
            trace_r <= 1'b0;
            iss_r   <= 1'b0;
            op_r    <= OP_SQR;
            rej_r   <= job.reject;
            st_r    <= job.reject ? E_EMIT : E_MUL;
          end
        end
        E_MUL: begin
          if (mul_start) iss_r <= 1'b1;
          if (mul_done) begin
            iss_r <= 1'b0;
            case (op_r)
              OP_SQR:   op_r <= OP_SQI;
              OP_SQI: begin
                if (!trace_r) begin
                  st_r <= E_CHECK;
                end else if (fresh_r) begin
                  fresh_r <= 1'b0;
                  op_r    <= OP_PIXX;
                end else begin
                  st_r <= E_EMIT;
                end
              end
              OP_CROSS: op_r <= OP_SQR;
              OP_PIXX:  op_r <= OP_PIXY;
              OP_PIXY:  op_r <= OP_PIXM;
              default:  op_r <= OP_CROSS;
            endcase
          end
        end
        E_CHECK: begin
          if (cont) begin
            op_r <= OP_CROSS;
            st_r <= E_MUL;
          end else if (in_range) begin
            trace_r <= 1'b1;
            fresh_r <= 1'b1;
            op_r    <= OP_SQR;
            st_r    <= E_MUL;
          end else begin
            rej_r <= 1'b1;
            st_r  <= E_EMIT;
          end
        end
        E_EMIT: begin
          if (res_ready) begin
            if (rej_r || last_r) begin
              st_r <= E_IDLE;
            end else begin
              op_r <= OP_PIXX;
              st_r <= E_MUL;
            end
          end
        end
        default: st_r <= E_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == E_IDLE && job_valid) begin
      cr_r <= job.cr;
      ci_r <= job.ci;
      zr_r <= W'(job.cr);
      zi_r <= W'(job.ci);
      n_r  <= '0;
    end
    if (st_r == E_CHECK && !cont) begin
      // restart the orbit from c for the trace
      zr_r <= W'(cr_r);
      zi_r <= W'(ci_r);
      i_r  <= '0;
    end
    if (st_r == E_EMIT && res_ready) i_r <= i_r + BAND_W'(1);
    if (mul_done) begin
      case (op_r)
        OP_SQR: a_r <= sat;
        OP_SQI: begin
          b_r <= sat;
          if (trace_r && !fresh_r) last_r <= done_now;
        end
        OP_CROSS: begin
          zr_r <= re_cl;
          zi_r <= im_cl;
          n_r  <= n_r + 17'd1;
        end
        OP_PIXX: begin px_r <= pval; okx_r <= pok; end
        OP_PIXY: begin py_r <= pval; oky_r <= pok; end
        default: begin pm_r <= pval; okm_r <= pok; end
      endcase
    end
  end

  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (!rej_r) begin
      res.pixel_x        = px_r;
      res.pixel_y        = py_r;
      res.pixel_y_mirror = pm_r;
      res.draw           = okx_r && oky_r && okm_r;
      res.red_hit        = in_band(i_r, cfg.bands[11:0]);
      res.green_hit      = in_band(i_r, cfg.bands[23:12]);
      res.blue_hit       = in_band(i_r, cfg.bands[35:24]);
      res.last           = last_r;
    end
  end

  assign job_ready = (st_r == E_IDLE);
  assign res_valid = (st_r == E_EMIT);

endmodule

>>> rtl/core/buddhabrot_orbit_tracer.sv
// ----------------------------------------------------------------------------
// buddhabrot_orbit_tracer
// Escape test and orbit trace of Buddhabrot sample points, queue-style ports.
// ----------------------------------------------------------------------------
// Usage: push a sample point c on in_data while full is low. Results come out
// oldest first on out_data while empty is low; pop takes one. A point gives
// either a single result with draw clear and last set (inside the cardioid or
// bulb, no escape by max_iterations, or an escape before min_iterations), or
// one result per traced orbit step, the final one marked by last.
// Flow: the front runs the bulb test, then the engine runs the escape
// iterations and the traced steps; the front and the engine each pass their
// products through one half-width multiplier in four partial products, so
// that multiplier sets the rate. One point is worked on at a time while the
// next is classified and queued.
// Stalls: a result waits in the output register while pop is low; the engine
// holds its state until the register is taken, and the front keeps accepting
// points until the queue fills.
// Reset: all control state clears, the queues empty and the configuration
// registers take their default values. Write configuration only when idle.
// ----------------------------------------------------------------------------
module buddhabrot_orbit_tracer import bbot_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TRACE_MAX  = TRACE_MAX_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  in_item_t          in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t        cfg_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  job_t        fq_job, bq_job;
  logic        res_valid, res_ready;
  out_item_t   res;
  logic        out_valid_r;
  out_item_t   out_r;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iter   <= MAX_ITER_RST;
      cfg_r.min_iter   <= MIN_ITER_RST;
      cfg_r.bands      <= BANDS_RST;
      cfg_r.view_left  <= VIEW_LEFT_RST;
      cfg_r.view_top   <= VIEW_TOP_RST;
      cfg_r.x_ppu      <= X_PPU_RST;
      cfg_r.y_ppu      <= Y_PPU_RST;
      cfg_r.image_size <= IMAGE_SIZE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_ITER:  cfg_r.max_iter   <= pwdata[15:0];
        REG_MIN_ITER:  cfg_r.min_iter   <= pwdata[15:0];
        REG_BANDS:     cfg_r.bands      <= pwdata[35:0];
        REG_VIEW_LEFT: cfg_r.view_left  <= pwdata[31:0];
        REG_VIEW_TOP:  cfg_r.view_top   <= pwdata[31:0];
        REG_X_PPU:     cfg_r.x_ppu      <= pwdata[31:0];
        REG_Y_PPU:     cfg_r.y_ppu      <= pwdata[31:0];
        default:       cfg_r.image_size <= pwdata[23:0];
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_ITER:  prdata = CFG_DW'(cfg_r.max_iter);
      REG_MIN_ITER:  prdata = CFG_DW'(cfg_r.min_iter);
      REG_BANDS:     prdata = CFG_DW'(cfg_r.bands);
      REG_VIEW_LEFT: prdata = CFG_DW'($unsigned(cfg_r.view_left));
      REG_VIEW_TOP:  prdata = CFG_DW'($unsigned(cfg_r.view_top));
      REG_X_PPU:     prdata = CFG_DW'(cfg_r.x_ppu);
      REG_Y_PPU:     prdata = CFG_DW'(cfg_r.y_ppu);
      default:       prdata = CFG_DW'(cfg_r.image_size);
    endcase
  end

  bbot_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .full      (full),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  bbot_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_job),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_data  (bq_job)
  );

  bbot_engine #(
    .FRAC_BITS  (FRAC_BITS),
    .TRACE_MAX  (TRACE_MAX),
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_valid (bq_valid),
    .job_ready (bq_ready),
    .job       (bq_job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: refill in the same cycle as a pop
  assign res_ready = !out_valid_r || pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_r <= res;
  end

  assign empty    = !out_valid_r;
  assign out_data = out_r;

  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    push && !full |=> full)
    else $error("front not busy after an accepted point");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> !empty)
    else $error("transfer into output register lost");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("result or front state left over after reset");

endmodule

>>> dv/buddhabrot_orbit_tracer_tb.sv
// ----------------------------------------------------------------------------
// buddhabrot_orbit_tracer_tb
// Self-checking bench for the Buddhabrot orbit tracer.
// ----------------------------------------------------------------------------
// A directed table runs first: rejects under the reset settings, then
// boundary points, saturating points and an empty colour band under a short
// iteration budget. Random phases follow with new register settings each
// time, including scale and image extremes. Every transfer on the result side
// is checked against a predictor of the escape test and the orbit trace. The
// phases cover no idling, a mostly idle sender, a mostly stalled receiver
// with one long hold-off, and light idling on both sides.
// ----------------------------------------------------------------------------
module buddhabrot_orbit_tracer_tb import bbot_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q    = 64'sd1 << 28;
  localparam longint Z_SAT    = (64'sd1 << 39) - 1;
  localparam longint SQ_SAT   = 64'sd1 << 36;
  localparam longint PIX_SAT  = 64'sd1 << 40;
  localparam longint PIX_TOP  = 64'hF_FFFF;
  localparam longint RUN_LIMIT = 64'd8_000_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    in_item_t  pt;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  in_item_t          in_data = '0;
  logic              full;
  logic              empty;
  logic              pop = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  cfg_t        tracer_cfg;
  out_item_t   orbit_q[$];
  int          error_count = 0;
  int          result_count = 0;
  longint      cycle_count = 0;
  idle_mode_t  idle_mode = IDLE_NONE;
  int          hold_len = 0;
  int          hold_seq = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  stim_row_t   rows[$];

  buddhabrot_orbit_tracer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("buddhabrot_orbit_tracer: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint q_const(longint num, longint den);
    return ((num << 28) + den / 2) / den;
  endfunction

  // exact product, truncated toward zero, magnitude saturated at sat
  function automatic longint mul_trunc(longint a, longint b, int sh, longint sat);
    logic [127:0] ma, mb, p;
    ma = (a < 0) ? 128'(-a) : 128'(a);
    mb = (b < 0) ? 128'(-b) : 128'(b);
    p  = (ma * mb) >> sh;
    if (p > 128'(sat)) p = 128'(sat);
    return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint clamp_z(longint v);
    if (v > Z_SAT) return Z_SAT;
    if (v < -Z_SAT) return -Z_SAT;
    return v;
  endfunction

  function automatic longint mag_sq(longint re, longint im);
    return mul_trunc(re, re, 28, SQ_SAT) + mul_trunc(im, im, 28, SQ_SAT);
  endfunction

  function automatic void z_update(ref longint re, ref longint im, input longint cr,
                                   input longint ci);
    longint a, b, p;
    a  = mul_trunc(re, re, 28, Z_SAT);
    b  = mul_trunc(im, im, 28, Z_SAT);
    p  = mul_trunc(re, im, 28, Z_SAT);
    re = clamp_z(a - b + cr);
    im = clamp_z(2 * p + ci);
  endfunction

  function automatic logic [PIX_W-1:0] axis_pixel(longint d, longint ppu, longint size,
                                                  output bit ok);
    longint pix;
    pix = mul_trunc(d, ppu, 36, PIX_SAT);
    ok  = (d >= 0 || ppu == 0) && size >= 2 && pix < (size - 1) * 256;
    if (pix < 0) pix = 0;
    if (pix > PIX_TOP) pix = PIX_TOP;
    return pix[PIX_W-1:0];
  endfunction

  function automatic int band_edge(int k);
    return int'(tracer_cfg.bands[6*k +: 6]);
  endfunction

  function automatic bit band_hit(int step, int b);
    return step >= band_edge(2 * b) && step <= band_edge(2 * b + 1);
  endfunction

  function automatic void expect_result(out_item_t r);
    orbit_q = {orbit_q, r};
  endfunction

  // queue every result that one sample point produces
  function automatic void trace_orbit(in_item_t pt);
    longint cr, ci, zr, zi, c2r, vl, vt, xp, yp;
    longint w, h;
    int n, top;
    bit reject, okx, oky, okm, done;
    out_item_t r;
    cr  = longint'(pt.point_real);
    ci  = longint'(pt.point_imag);
    vl  = longint'(tracer_cfg.view_left);
    vt  = longint'(tracer_cfg.view_top);
    xp  = longint'({32'd0, tracer_cfg.x_ppu});
    yp  = longint'({32'd0, tracer_cfg.y_ppu});
    w   = longint'(tracer_cfg.image_size[11:0]);
    h   = longint'(tracer_cfg.image_size[23:12]);
    c2r = mul_trunc(q_const(108, 100), cr, 28, Z_SAT) + q_const(15, 100);
    reject = mag_sq(cr + ONE_Q, ci) < q_const(6, 100) ||
             (c2r < q_const(42, 100) && mag_sq(c2r, ci) < q_const(417, 1000));
    if (!reject) begin
      zr = clamp_z(cr);
      zi = clamp_z(ci);
      n  = 0;
      while (n <= int'(tracer_cfg.max_iter) && mag_sq(zr, zi) < 4 * ONE_Q) begin
        z_update(zr, zi, cr, ci);
        n++;
      end
      reject = !(n <= int'(tracer_cfg.max_iter) && n >= int'(tracer_cfg.min_iter));
    end
    if (reject) begin
      r = '0;
      r.last = 1'b1;
      expect_result(r);
      return;
    end
    top = 0;
    for (int b = 0; b < 3; b++)
      if (band_edge(2 * b + 1) > top) top = band_edge(2 * b + 1);
    zr = clamp_z(cr);
    zi = clamp_z(ci);
    for (int step = 0; step <= top; step++) begin
      r.pixel_x        = axis_pixel(zr - vl, xp, w, okx);
      r.pixel_y        = axis_pixel(zi - vt, yp, h, oky);
      r.pixel_y_mirror = axis_pixel(-zi - vt, yp, h, okm);
      r.draw           = okx && oky && okm;
      r.red_hit        = band_hit(step, 0);
      r.green_hit      = band_hit(step, 1);
      r.blue_hit       = band_hit(step, 2);
      z_update(zr, zi, cr, ci);
      done   = mag_sq(zr, zi) >= 4 * ONE_Q || step == top;
      r.last = done;
      expect_result(r);
      if (done) break;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string field, longint got, longint want);
    $display("result %0d: %s got 0x%0h, expected 0x%0h", result_count, field, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (orbit_q.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = orbit_q.pop_front();
        if (out_data.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", out_data.pixel_x, want.pixel_x);
        if (out_data.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", out_data.pixel_y, want.pixel_y);
        if (out_data.pixel_y_mirror !== want.pixel_y_mirror)
          report_mismatch("pixel_y_mirror", out_data.pixel_y_mirror, want.pixel_y_mirror);
        if (out_data.draw !== want.draw)
          report_mismatch("draw", out_data.draw, want.draw);
        if (out_data.red_hit !== want.red_hit)
          report_mismatch("red_hit", out_data.red_hit, want.red_hit);
        if (out_data.green_hit !== want.green_hit)
          report_mismatch("green_hit", out_data.green_hit, want.green_hit);
        if (out_data.blue_hit !== want.blue_hit)
          report_mismatch("blue_hit", out_data.blue_hit, want.blue_hit);
        if (out_data.last !== want.last)
          report_mismatch("last", out_data.last, want.last);
      end
      result_count <= result_count + 1;
    end
  end

  // receiver: random stalls, or a long hold-off while hold_left runs down
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= hold_len;
      pop       <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: pop <= $urandom_range(99) >= 84;
        IDLE_BOTH:     pop <= $urandom_range(99) >= 13;
        default:       pop <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic reg_write(logic [2:0] idx, logic [CFG_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_settings(cfg_t c);
    reg_write(REG_MAX_ITER, 64'(c.max_iter));
    reg_write(REG_MIN_ITER, 64'(c.min_iter));
    reg_write(REG_BANDS, 64'(c.bands));
    reg_write(REG_VIEW_LEFT, 64'(unsigned'(c.view_left)));
    reg_write(REG_VIEW_TOP, 64'(unsigned'(c.view_top)));
    reg_write(REG_X_PPU, 64'(c.x_ppu));
    reg_write(REG_Y_PPU, 64'(c.y_ppu));
    reg_write(REG_IMAGE_SIZE, 64'(c.image_size));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracer_cfg = c;
    @(posedge clk);
  endtask

  task automatic send_point(in_item_t pt);
    push    <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (full);
    trace_orbit(pt);
  endtask

  // hold the sender until every queued result has gone out
  task automatic drain();
    push <= 1'b0;
    while (orbit_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic sender_gap();
    int pct;
    pct = (idle_mode == IDLE_SENDER) ? 84 : (idle_mode == IDLE_BOTH) ? 13 : 0;
    while ($urandom_range(99) < pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic run_rows();
    foreach (rows[k]) begin
      sender_gap();
      if (rows[k].typed) begin
        push    <= 1'b1;
        in_data <= rows[k].pt;
        do @(posedge clk); while (full);
        expect_result(rows[k].want);
      end else begin
        send_point(rows[k].pt);
      end
    end
    rows.delete();
    drain();
  endtask

  function automatic logic [31:0] q428(real v);
    return 32'($rtoi(v * 268435456.0));
  endfunction

  function automatic logic [35:0] pack_bands(int rl, int rh, int gl, int gh, int bl, int bh);
    return {6'(bh), 6'(bl), 6'(gh), 6'(gl), 6'(rh), 6'(rl)};
  endfunction

  function automatic void add_row(logic [31:0] re, logic [31:0] im, bit typed);
    stim_row_t row;
    row.pt.point_real = re;
    row.pt.point_imag = im;
    row.typed         = typed;
    row.want          = '0;
    row.want.last     = 1'b1;
    rows = {rows, row};
  endfunction

  // mostly points near the set, some full-range raw words; far_only: |re| >= 2
  function automatic in_item_t random_point(bit far_only);
    in_item_t pt;
    longint re;
    if (far_only || $urandom_range(99) < 20) begin
      pt.point_real = $urandom;
      pt.point_imag = $urandom;
      if (far_only) begin
        re = longint'(pt.point_real);
        if (re >= -(64'sd1 << 29) && re < (64'sd1 << 29))
          re = re + ((re >= 0) ? (64'sd1 << 29) : -(64'sd1 << 29));
        pt.point_real = re[31:0];
      end
    end else begin
      pt.point_real = 32'($urandom_range(0, 805306368)) - 32'd536870912;
      pt.point_imag = 32'($urandom_range(0, 644245094)) - 32'd322122547;
    end
    return pt;
  endfunction

  task automatic random_phase(cfg_t c, idle_mode_t mode, int count, bit far_only,
                              int hold, bit mid_pause);
    load_settings(c);
    idle_mode = mode;
    if (hold > 0) begin
      hold_len = hold;
      hold_seq++;
    end
    for (int k = 0; k < count; k++) begin
      if (mid_pause && k == count / 2) drain();
      sender_gap();
      send_point(random_point(far_only));
    end
    drain();
  endtask

  function automatic cfg_t base_settings();
    cfg_t c;
    c.max_iter   = MAX_ITER_RST;
    c.min_iter   = MIN_ITER_RST;
    c.bands      = BANDS_RST;
    c.view_left  = VIEW_LEFT_RST;
    c.view_top   = VIEW_TOP_RST;
    c.x_ppu      = X_PPU_RST;
    c.y_ppu      = Y_PPU_RST;
    c.image_size = IMAGE_SIZE_RST;
    return c;
  endfunction

  initial begin
    cfg_t c;
    tracer_cfg = base_settings();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: cardioid, bulb, and escapes far short of min_iterations
    add_row(32'h0000_0000, 32'h0000_0000, 1'b1);
    add_row(q428(-1.0), 32'h0000_0000, 1'b1);
    add_row(q428(-0.1), q428(0.2), 1'b1);
    add_row(q428(3.0), 32'h0000_0000, 1'b1);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    add_row(32'h8000_0000, 32'h8000_0000, 1'b1);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_row(q428(0.3), 32'h0000_0000, 1'b0);
    run_rows();

    // short budget, empty green band, every escape traced
    c = base_settings();
    c.max_iter = 16'd100;
    c.min_iter = 16'd0;
    c.bands    = pack_bands(2, 10, 5, 1, 11, 20);
    load_settings(c);
    add_row(q428(-2.0), 32'h0000_0000, 1'b0);
    add_row(q428(2.0), 32'h0000_0000, 1'b0);
    add_row(32'h0000_0000, q428(2.0), 1'b0);
    add_row(q428(0.26), 32'h0000_0000, 1'b0);
    add_row(q428(0.3), q428(0.02), 1'b0);
    add_row(q428(-0.75), q428(0.1), 1'b0);
    add_row(q428(-0.1), q428(0.9), 1'b0);
    add_row(q428(-1.3107), 32'h0000_0000, 1'b0);
    add_row(q428(-1.78), q428(0.01), 1'b0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_row(32'h8000_0000, 32'h0000_0000, 1'b0);
    add_row(q428(-0.2), q428(-1.1), 1'b0);
    add_row(q428(0.45), q428(-0.35), 1'b0);
    run_rows();

    c = base_settings();
    c.max_iter = 16'd64;
    c.min_iter = 16'd0;
    random_phase(c, IDLE_NONE, 14, 1'b0, 0, 1'b0);

    c.max_iter = 16'd100;
    c.min_iter = 16'd3;
    c.bands    = '1;
    random_phase(c, IDLE_SENDER, 14, 1'b0, 0, 1'b0);

    // random window; the receiver holds off long enough for the input to stall
    c.max_iter   = 16'd80;
    c.min_iter   = 16'd0;
    c.bands      = 36'($urandom) ^ (36'($urandom) << 4);
    c.view_left  = $urandom;
    c.view_top   = $urandom;
    c.x_ppu      = $urandom;
    c.y_ppu      = $urandom;
    c.image_size = 24'($urandom);
    random_phase(c, IDLE_RECEIVER, 22, 1'b0, 4000, 1'b0);

    // largest budget with escapes on the first step; scale and size extremes
    c.max_iter   = 16'hFFFF;
    c.min_iter   = 16'd0;
    c.bands      = '0;
    c.view_left  = 32'h8000_0000;
    c.view_top   = 32'h7FFF_FFFF;
    c.x_ppu      = 32'd0;
    c.y_ppu      = 32'hFFFF_FFFF;
    c.image_size = 24'hFF_FFFF;
    random_phase(c, IDLE_BOTH, 14, 1'b1, 0, 1'b0);

    c.max_iter   = 16'd0;
    c.min_iter   = 16'hFFFF;
    c.view_left  = 32'h7FFF_FFFF;
    c.view_top   = 32'h8000_0000;
    c.x_ppu      = 32'hFFFF_FFFF;
    c.y_ppu      = 32'd0;
    c.image_size = 24'd1;
    random_phase(c, IDLE_NONE, 8, 1'b0, 0, 1'b0);

    c.max_iter   = 16'd120;
    c.min_iter   = 16'd10;
    c.bands      = 36'($urandom) ^ (36'($urandom) << 4);
    c.view_left  = VIEW_LEFT_RST;
    c.view_top   = VIEW_TOP_RST;
    c.x_ppu      = X_PPU_RST;
    c.y_ppu      = Y_PPU_RST;
    c.image_size = 24'h000_000;
    random_phase(c, IDLE_BOTH, 14, 1'b0, 0, 1'b1);

    repeat (200) @(posedge clk);
    if (error_count == 0 && orbit_q.size() == 0)
      $display("buddhabrot_orbit_tracer: match");
    else
      $display("buddhabrot_orbit_tracer: mismatch");
    $finish;
  end

endmodule
